// ===== rtl/core/hls_color_shade_macros.svh =====
// assertion helpers used by hls_color_shade
`ifndef HLS_COLOR_SHADE_MACROS_SVH
`define HLS_COLOR_SHADE_MACROS_SVH

// same-cycle implication, checked on the rising clock outside reset
`define HCS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock outside reset
`define HCS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/hcs_pkg.sv =====
package hcs_pkg;

   // fixed point constants
   localparam logic [16:0] ONE_Q16  = 17'd65536;
   localparam logic [16:0] HALF_Q16 = 17'd32768;
   localparam logic [17:0] TWO_Q16  = 18'd131072;

   // hue in degrees with 8 fraction bits
   localparam logic signed [18:0] HUE_60  = 19'sd15360;
   localparam logic signed [18:0] HUE_120 = 19'sd30720;
   localparam logic signed [18:0] HUE_180 = 19'sd46080;
   localparam logic signed [18:0] HUE_240 = 19'sd61440;
   localparam logic signed [18:0] HUE_360 = 19'sd92160;
   localparam logic [16:0]        HUE_60_U = 17'd15360;

   // ceil(2^23 / 15), exact for dividends below 2^20
   localparam logic [19:0] RECIP15 = 20'd559241;

   // quotient bits of both dividers
   localparam int DIV_QW = 17;

   // which channel holds the maximum
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // hue sector of one output channel
   localparam logic [1:0] SEC_RISE = 2'd0;
   localparam logic [1:0] SEC_HIGH = 2'd1;
   localparam logic [1:0] SEC_FALL = 2'd2;
   localparam logic [1:0] SEC_LOW  = 2'd3;

   // data that rides alongside the dividers
   typedef struct packed {
      logic        gray;
      logic        neg;
      logic [16:0] base;
      logic [16:0] lig;
      logic [15:0] k;
   } side_type;

endpackage

// ===== rtl/core/hcs_div.sv =====
module hcs_div #(
   parameter int NW = 33,
   parameter int DW = 17,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   // one restoring step per stage, quotient must fit in QW bits
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   genvar k;
   generate
      for (k = 0; k < QW; k++) begin : g_stage
         logic [DW-1:0] rem_prev;
         logic [QW-1:0] low_prev;
         logic [DW-1:0] den_prev;
         logic [QW-1:0] quo_prev;
         logic [DW:0]   trial;
         logic          ge;
         logic [DW-1:0] rem_in;
         logic [QW-1:0] low_in;
         logic [QW-1:0] quo_in;

         if (k == 0) begin : g_first
            assign rem_prev = DW'(num >> QW);
            assign low_prev = num[QW-1:0];
            assign den_prev = den;
            assign quo_prev = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign low_prev = low_ff[k-1];
            assign den_prev = den_ff[k-1];
            assign quo_prev = quo_ff[k-1];
         end

         always_comb begin
            trial  = {rem_prev, low_prev[QW-1]};
            ge     = (trial >= {1'b0, den_prev});
            rem_in = ge ? DW'(trial - {1'b0, den_prev}) : trial[DW-1:0];
            low_in = {low_prev[QW-2:0], 1'b0};
            quo_in = {quo_prev[QW-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               low_ff[k] <= low_in;
               den_ff[k] <= den_prev;
               quo_ff[k] <= quo_in;
            end
         end
      end
   endgenerate

   assign quo = quo_ff[QW-1];

endmodule

// ===== rtl/core/hls_color_shade.sv =====
// hls_color_shade: shades one rgb color in hue / lightness / saturation space
// request channel: req_valid with req_red_in, req_green_in, req_blue_in and
//    req_shade_factor (13 fraction bits, 8192 = 1.0); taken when req_valid is
//    high and req_stall is low
// response channel: rsp_valid with rsp_red_out, rsp_green_out, rsp_blue_out;
//    taken when rsp_valid is high and rsp_stall is low
// throughput: one request per clock, back to back, while the pipeline is not frozen
// stages: the accepting edge loads the input register; then come the min/max
//    stage, the two one-bit-per-stage dividers side by side (saturation and
//    hue), hue assembly, the shade clamp, the lightness times saturation
//    multiply, the m1/m2 stage and the per-channel interpolation multiply
//    and divide-by-15360
// the whole pipeline moves on one enable: it advances whenever the output
//    register is empty or being taken, so a stall only freezes it while a
//    result is waiting; nothing is lost or repeated
// reset (synchronous, active high) clears all stage valid bits; payload
//    registers keep whatever they hold
`include "hls_color_shade_macros.svh"

module hls_color_shade
   import hcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_red_in,
   input  logic [15:0] req_green_in,
   input  logic [15:0] req_blue_in,
   input  logic [15:0] req_shade_factor,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_red_out,
   output logic [15:0] rsp_green_out,
   output logic [15:0] rsp_blue_out
);

   // stage positions in the valid line
   localparam int V_X   = 0;
   localparam int V_MM  = 1;
   localparam int V_DIV = V_MM + DIV_QW;
   localparam int V_H   = V_DIV + 1;
   localparam int V_S   = V_H + 1;
   localparam int V_M   = V_S + 1;
   localparam int V_M2  = V_M + 1;
   localparam int V_C   = V_M2 + 1;
   localparam int V_OUT = V_C + 1;
   localparam int NSTG  = V_OUT + 1;

   logic            en;
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;

   // pipeline advances when the output slot is free or being drained
   assign en        = !vld_ff[V_OUT] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[V_OUT];
   assign vld_in    = {vld_ff[NSTG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- stage x: channels to q16 ----------------
   // floor((c*65536 + 32767) / 65535) is c plus one when c >= 32768
   logic [16:0] x_r_in, x_g_in, x_b_in;
   logic [16:0] x_r_ff, x_g_ff, x_b_ff;
   logic [15:0] k1_ff;

   always_comb begin
      x_r_in = {1'b0, req_red_in}   + 17'(req_red_in[15]);
      x_g_in = {1'b0, req_green_in} + 17'(req_green_in[15]);
      x_b_in = {1'b0, req_blue_in}  + 17'(req_blue_in[15]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_r_ff <= x_r_in;
         x_g_ff <= x_g_in;
         x_b_ff <= x_b_in;
         k1_ff  <= req_shade_factor;
      end
   end

   // ---------------- stage mm: max, min, sum, delta ----------------
   logic [16:0] mx_in, mn_in, rg_max, rg_min;
   logic [1:0]  sel_in;
   logic [17:0] sum_in;
   logic [16:0] d_in;
   logic [16:0] r2_ff, g2_ff, b2_ff, d2_ff;
   logic [1:0]  sel2_ff;
   logic [17:0] sum2_ff;
   logic [15:0] k2_ff;

   always_comb begin
      rg_max = (x_r_ff > x_g_ff) ? x_r_ff : x_g_ff;
      rg_min = (x_r_ff < x_g_ff) ? x_r_ff : x_g_ff;
      mx_in  = (x_b_ff > rg_max) ? x_b_ff : rg_max;
      mn_in  = (x_b_ff < rg_min) ? x_b_ff : rg_min;
      // ties: red wins over green, green over blue
      if (x_r_ff == mx_in) begin
         sel_in = CH_RED;
      end else if (x_g_ff == mx_in) begin
         sel_in = CH_GREEN;
      end else begin
         sel_in = CH_BLUE;
      end
      sum_in = {1'b0, mx_in} + {1'b0, mn_in};
      d_in   = mx_in - mn_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff   <= x_r_ff;
         g2_ff   <= x_g_ff;
         b2_ff   <= x_b_ff;
         sel2_ff <= sel_in;
         sum2_ff <= sum_in;
         d2_ff   <= d_in;
         k2_ff   <= k1_ff;
      end
   end

   // ---------------- divider feed ----------------
   logic signed [17:0] num_s;
   logic [16:0]        mag;
   logic [16:0]        sden;
   logic [32:0]        sdvd;
   logic [29:0]        hdvd;
   side_type           side_in;
   side_type           side_ff [DIV_QW];
   logic [DIV_QW-1:0]  sat_q, hue_q;

   always_comb begin
      // saturation denominator folds at lightness one half
      if (sum2_ff <= {1'b0, ONE_Q16}) begin
         sden = sum2_ff[16:0];
      end else begin
         sden = 17'(TWO_Q16 - sum2_ff);
      end
      case (sel2_ff)
         CH_RED: begin
            num_s = $signed({1'b0, g2_ff}) - $signed({1'b0, b2_ff});
            side_in.base = 17'd0;
         end
         CH_GREEN: begin
            num_s = $signed({1'b0, b2_ff}) - $signed({1'b0, r2_ff});
            side_in.base = 17'(HUE_120);
         end
         default: begin
            num_s = $signed({1'b0, r2_ff}) - $signed({1'b0, g2_ff});
            side_in.base = 17'(HUE_240);
         end
      endcase
      side_in.neg  = num_s[17];
      mag          = num_s[17] ? 17'(-num_s) : 17'(num_s);
      // 15360 * |num| as two shifts
      hdvd         = ({13'b0, mag} << 14) - ({13'b0, mag} << 10);
      sdvd         = {d2_ff, 16'b0};
      side_in.gray = (d2_ff == 17'd0);
      side_in.lig  = sum2_ff[17:1];
      side_in.k    = k2_ff;
   end

   hcs_div #(.NW(33), .DW(17), .QW(DIV_QW)) u_sat_div (
      .clock (clock),
      .en    (en),
      .num   (sdvd),
      .den   (sden),
      .quo   (sat_q)
   );

   hcs_div #(.NW(30), .DW(17), .QW(DIV_QW)) u_hue_div (
      .clock (clock),
      .en    (en),
      .num   (hdvd),
      .den   (d2_ff),
      .quo   (hue_q)
   );

   // side data delay line matched to the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < DIV_QW; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // ---------------- stage h: hue assembly, shade products ----------------
   side_type           sd;
   logic signed [18:0] hq_s, hue_raw;
   logic [16:0]        hue_h_in, sat_h;
   logic [32:0]        plig_in, psat_in;
   logic [16:0]        hue_h_ff;
   logic [32:0]        plig_ff, psat_ff;

   always_comb begin
      sd      = side_ff[DIV_QW-1];
      hq_s    = $signed({2'b0, hue_q});
      hue_raw = $signed({2'b0, sd.base}) + (sd.neg ? -hq_s : hq_s);
      if (hue_raw < 0) begin
         hue_raw = hue_raw + HUE_360;
      end
      // gray input: hue and saturation zero
      hue_h_in = sd.gray ? 17'd0 : hue_raw[16:0];
      sat_h    = sd.gray ? 17'd0 : sat_q;
      plig_in  = {16'b0, sd.lig} * {17'b0, sd.k};
      psat_in  = {16'b0, sat_h} * {17'b0, sd.k};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_h_ff <= hue_h_in;
         plig_ff  <= plig_in;
         psat_ff  <= psat_in;
      end
   end

   // ---------------- stage s: scale and clamp ----------------
   logic [16:0] lig_s_in, sat_s_in;
   logic [16:0] lig_s_ff, sat_s_ff, hue_s_ff;

   always_comb begin
      lig_s_in = (plig_ff[32:13] > {3'b0, ONE_Q16}) ? ONE_Q16 : plig_ff[29:13];
      sat_s_in = (psat_ff[32:13] > {3'b0, ONE_Q16}) ? ONE_Q16 : psat_ff[29:13];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lig_s_ff <= lig_s_in;
         sat_s_ff <= sat_s_in;
         hue_s_ff <= hue_h_ff;
      end
   end

   // ---------------- stage m: lightness times saturation ----------------
   logic [33:0] pls_in;
   logic [33:0] pls_ff;
   logic [16:0] lig_m_ff, sat_m_ff, hue_m_ff;

   assign pls_in = {17'b0, lig_s_ff} * {17'b0, sat_s_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         pls_ff   <= pls_in;
         lig_m_ff <= lig_s_ff;
         sat_m_ff <= sat_s_ff;
         hue_m_ff <= hue_s_ff;
      end
   end

   // ---------------- stage m2: m1, m2 and hue sectors ----------------
   logic [17:0]        ph;
   logic [18:0]        lig2, m2a, m1_in, m2_in;
   logic signed [18:0] toff [3];
   logic signed [18:0] tch;
   logic [1:0]         sec_in [3];
   logic [13:0]        tt_in [3];
   logic [18:0]        m1_ff, m2_ff, span_ff;
   logic [1:0]         sec_ff [3];
   logic [13:0]        tt_ff [3];
   logic               flat_ff;
   logic [16:0]        lig2_ff;

   assign toff[0] = HUE_120;
   assign toff[1] = 19'sd0;
   assign toff[2] = -HUE_120;

   always_comb begin
      // l*(1+s) below one half, l+s-l*s above
      ph   = pls_ff[33:16];
      lig2 = {1'b0, lig_m_ff, 1'b0};
      if (lig_m_ff <= HALF_Q16) begin
         m2a = 19'(lig_m_ff) + 19'(ph);
      end else begin
         m2a = 19'(lig_m_ff) + 19'(sat_m_ff) - 19'(ph);
      end
      m1_in = (lig2 >= m2a) ? lig2 - m2a : 19'd0;
      m2_in = (m2a < m1_in) ? m1_in : m2a;
      tch   = 19'sd0;
      for (int c = 0; c < 3; c++) begin
         tch = $signed({2'b0, hue_m_ff}) + toff[c];
         if (tch > HUE_360) begin
            tch = tch - HUE_360;
         end
         if (tch < 0) begin
            tch = tch + HUE_360;
         end
         if (tch < HUE_60) begin
            sec_in[c] = SEC_RISE;
            tt_in[c]  = tch[13:0];
         end else if (tch < HUE_180) begin
            sec_in[c] = SEC_HIGH;
            tt_in[c]  = 14'd0;
         end else if (tch < HUE_240) begin
            sec_in[c] = SEC_FALL;
            tt_in[c]  = 14'(HUE_240 - tch);
         end else begin
            sec_in[c] = SEC_LOW;
            tt_in[c]  = 14'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         span_ff <= m2_in - m1_in;
         flat_ff <= (sat_m_ff == 17'd0);
         lig2_ff <= lig_m_ff;
         for (int c = 0; c < 3; c++) begin
            sec_ff[c] <= sec_in[c];
            tt_ff[c]  <= tt_in[c];
         end
      end
   end

   // ---------------- stage c: span times hue fraction ----------------
   logic [32:0] prod_in [3];
   logic [32:0] prod_ff [3];
   logic [1:0]  sec_c_ff [3];
   logic [18:0] m1_c_ff, m2_c_ff;
   logic        flat_c_ff;
   logic [16:0] lig_c_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = {14'b0, span_ff} * {19'b0, tt_ff[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[c]  <= prod_in[c];
            sec_c_ff[c] <= sec_ff[c];
         end
         m1_c_ff   <= m1_ff;
         m2_c_ff   <= m2_ff;
         flat_c_ff <= flat_ff;
         lig_c_ff  <= lig2_ff;
      end
   end

   // ---------------- stage out: /15360, pick, back to 16 bits ----------------
   // /15360 = shift by 10, then multiply by reciprocal of 15
   logic [39:0] rq [3];
   logic [18:0] v [3];
   logic [15:0] out_in [3];
   logic [15:0] out_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rq[c] = {20'b0, prod_ff[c][29:10]} * {20'b0, RECIP15};
         case (sec_c_ff[c])
            SEC_RISE: v[c] = m1_c_ff + 19'(rq[c][39:23]);
            SEC_HIGH: v[c] = m2_c_ff;
            SEC_FALL: v[c] = m1_c_ff + 19'(rq[c][39:23]);
            default:  v[c] = m1_c_ff;
         endcase
         // zero saturation: lightness on every channel
         if (flat_c_ff) begin
            v[c] = 19'(lig_c_ff);
         end
         // floor(min(v,1.0) * 65535 / 65536)
         if (v[c] >= 19'(ONE_Q16)) begin
            out_in[c] = 16'hFFFF;
         end else if (v[c] == 19'd0) begin
            out_in[c] = 16'd0;
         end else begin
            out_in[c] = 16'(v[c] - 19'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            out_ff[c] <= out_in[c];
         end
      end
   end

   assign rsp_red_out   = out_ff[0];
   assign rsp_green_out = out_ff[1];
   assign rsp_blue_out  = out_ff[2];

   // ---------------- checks ----------------
   logic shade_ok;

   assign shade_ok = (lig_s_ff <= ONE_Q16) && (sat_s_ff <= ONE_Q16);

   `HCS_ASSERT_NXT(a_freeze_on_stall, !en, $stable(vld_ff), "pipeline moved while frozen")
   `HCS_ASSERT_IMP(a_hue_range, vld_ff[V_H], hue_h_ff < 17'(HUE_360), "hue out of range")
   `HCS_ASSERT_IMP(a_shade_clamp, vld_ff[V_S], shade_ok, "shade clamp failed")
   `HCS_ASSERT_IMP(a_m_order, vld_ff[V_M2], m1_ff <= m2_ff, "m1 above m2")

endmodule
